/* sv/itrgb_pkg.sv */
// ----------------------------------------------------------------------------
// itrgb_pkg
// shared constants, register indexes and the stage tag of the palette unit
// ----------------------------------------------------------------------------
`default_nettype none

package itrgb_pkg;

  // default widths
  localparam int IterBitsDefault = 16;
  localparam int FracBitsDefault = 16;

  // configuration register file
  localparam int CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] RegMaxIter  = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegRotation = 2'd1;
  localparam int MaxIterReset = 256;

  // palette rotation codes, the unused code acts as no rotation
  localparam logic [1:0] RotNone = 2'd0;
  localparam logic [1:0] RotOne  = 2'd1;
  localparam logic [1:0] RotTwo  = 2'd2;

  // polynomial weights times full scale (8.5 * 255 kept doubled)
  localparam int ScaleBits = 13;
  localparam int ScaleA    = 2295;
  localparam int ScaleB    = 3825;
  localparam int ScaleC    = 4335;
  localparam int ColourMax = 255;

  // status that travels alongside each pipeline stage
  typedef struct packed {
    logic valid;
    logic black;
  } tag_t;

endpackage

`default_nettype wire

/* sv/iteration_to_rgb_palette_unit.sv */
// ----------------------------------------------------------------------------
// iteration_to_rgb_palette_unit
// maps one escape iteration count per pixel to an 8-bit rgb colour
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                  payload
//  in       sink       in_valid_i / in_ready_o    iteration_count_i
//  out      source     out_valid_o / out_ready_i  red_o, green_o, blue_o
//  cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
//  one request accepted per clock while the output is not stalled, through
//  an entry stage, one divider stage per quotient bit, five multiplier
//  stages and an output register
//  a stalled output freezes every stage at once, nothing is lost
//  reset clears the valid bits and the two registers, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module iteration_to_rgb_palette_unit #(
  parameter int ITER_BITS = itrgb_pkg::IterBitsDefault,
  parameter int FRAC_BITS = itrgb_pkg::FracBitsDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // pixel requests
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [ITER_BITS-1:0]            iteration_count_i,
  // colour results
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [7:0]                           red_o,
  output logic [7:0]                           green_o,
  output logic [7:0]                           blue_o,
  // register writes
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [itrgb_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [ITER_BITS-1:0]            cfg_data_i
);

  // configuration registers, the user must write only while the pipe is empty; the block does not enforce it
  logic [ITER_BITS-1:0] max_q;
  logic [1:0]           rot_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= ITER_BITS'(itrgb_pkg::MaxIterReset);
      rot_q <= itrgb_pkg::RotNone;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        itrgb_pkg::RegMaxIter:  max_q <= cfg_data_i;
        itrgb_pkg::RegRotation: rot_q <= cfg_data_i[1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // global advance: the whole pipe moves when the output slot is free or being taken
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // t = count / max as an unsigned fraction
  itrgb_pkg::tag_t      div_tag;
  logic [FRAC_BITS-1:0] div_t;

  itrgb_divider #(
    .ITER_BITS(ITER_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .count_i (iteration_count_i),
    .max_i   (max_q),
    .tag_o   (div_tag),
    .quot_o  (div_t)
  );

  // the three polynomials
  itrgb_pkg::tag_t poly_tag;
  logic [7:0]      pa, pb, pc;

  itrgb_poly #(
    .FRAC_BITS(FRAC_BITS)
  ) u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (div_tag),
    .t_i    (div_t),
    .tag_o  (poly_tag),
    .pa_o   (pa),
    .pb_o   (pb),
    .pc_o   (pc)
  );

  // channel permutation, black for zero counts and counts at or past the limit
  logic [7:0] red_d, green_d, blue_d;

  always_comb begin
    case (rot_q)
      itrgb_pkg::RotOne: begin
        red_d = pc; green_d = pa; blue_d = pb;
      end
      itrgb_pkg::RotTwo: begin
        red_d = pb; green_d = pc; blue_d = pa;
      end
      default: begin
        red_d = pa; green_d = pb; blue_d = pc;
      end
    endcase
    if (poly_tag.black) begin
      red_d   = '0;
      green_d = '0;
      blue_d  = '0;
    end
  end

  // output register
  logic       out_valid_q;
  logic [7:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= poly_tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

`default_nettype wire

/* sv/itrgb_divider.sv */
// ----------------------------------------------------------------------------
// itrgb_divider
// pipelined restoring divider, one quotient bit per stage, t = count / max
// ----------------------------------------------------------------------------
`default_nettype none

module itrgb_divider #(
  parameter int ITER_BITS = itrgb_pkg::IterBitsDefault,
  parameter int FRAC_BITS = itrgb_pkg::FracBitsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [ITER_BITS-1:0] count_i,
  input  wire logic [ITER_BITS-1:0] max_i,
  output itrgb_pkg::tag_t           tag_o,
  output logic      [FRAC_BITS-1:0] quot_o
);

  logic [ITER_BITS-1:0] rem_q [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] quo_q [FRAC_BITS+1];
  itrgb_pkg::tag_t      tag_q [FRAC_BITS+1];

  logic black;
  assign black = (count_i == '0) || (count_i >= max_i);

  // entry stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
    end else if (en_i) begin
      tag_q[0].valid <= valid_i;
      tag_q[0].black <= black;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= count_i;
      quo_q[0] <= '0;
    end
  end

  // one shift, compare and subtract per stage
  for (genvar s = 1; s <= FRAC_BITS; s++) begin : g_step
    logic [ITER_BITS:0]   shifted;
    logic [ITER_BITS-1:0] diff;
    logic                 take;

    assign shifted = {rem_q[s-1], 1'b0};
    assign take    = shifted >= {1'b0, max_i};
    assign diff    = shifted[ITER_BITS-1:0] - max_i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else if (en_i) begin
        tag_q[s] <= tag_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? diff : shifted[ITER_BITS-1:0];
        quo_q[s] <= {quo_q[s-1][FRAC_BITS-2:0], take};
      end
    end
  end

  assign tag_o  = tag_q[FRAC_BITS];
  assign quot_o = quo_q[FRAC_BITS];

endmodule

`default_nettype wire

/* sv/itrgb_poly.sv */
// ----------------------------------------------------------------------------
// itrgb_poly
// five-stage multiplier pipeline for the three palette polynomials
// ----------------------------------------------------------------------------
`default_nettype none

module itrgb_poly #(
  parameter int FRAC_BITS = itrgb_pkg::FracBitsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  itrgb_pkg::tag_t           tag_i,
  input  wire logic [FRAC_BITS-1:0] t_i,
  output itrgb_pkg::tag_t           tag_o,
  output logic      [7:0]           pa_o,
  output logic      [7:0]           pb_o,
  output logic      [7:0]           pc_o
);

  localparam int Stages = 5;
  localparam int PW     = 2 * FRAC_BITS;
  localparam int SW     = FRAC_BITS + itrgb_pkg::ScaleBits + 1;
  localparam logic [FRAC_BITS:0] One = {1'b1, {FRAC_BITS{1'b0}}};

  function automatic logic [7:0] clip8(input logic [13:0] v);
    clip8 = (v > 14'(itrgb_pkg::ColourMax)) ? 8'(itrgb_pkg::ColourMax) : v[7:0];
  endfunction

  // tag pipe
  itrgb_pkg::tag_t tag_q [Stages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
    end else if (en_i) begin
      tag_q[0] <= tag_i;
    end
  end

  for (genvar s = 1; s < Stages; s++) begin : g_tag
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else if (en_i) begin
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  // stage 1: t and 1 - t
  logic [FRAC_BITS-1:0] t_p1_q;
  logic [FRAC_BITS:0]   u_p1_q;

  // stage 2: squares
  logic [PW-1:0]        tt;
  logic [PW:0]          uu;
  logic [FRAC_BITS-1:0] t_p2_q, t2_p2_q;
  logic [FRAC_BITS:0]   u_p2_q, u2_p2_q;
  assign tt = PW'(t_p1_q) * PW'(t_p1_q);
  assign uu = (PW+1)'(u_p1_q) * (PW+1)'(u_p1_q);

  // stage 3: cubes
  logic [PW-1:0]        ttt;
  logic [PW:0]          uuu;
  logic [FRAC_BITS-1:0] t_p3_q, t2_p3_q, t3_p3_q;
  logic [FRAC_BITS:0]   u_p3_q, u2_p3_q, u3_p3_q;
  assign ttt = PW'(t2_p2_q) * PW'(t_p2_q);
  assign uuu = (PW+1)'(u2_p2_q) * (PW+1)'(u_p2_q);

  // stage 4: cross products
  logic [PW:0]        ma, mb, mc;
  logic [FRAC_BITS:0] pa_p4_q, pb_p4_q, pc_p4_q;
  assign ma = (PW+1)'(u_p3_q) * (PW+1)'(t3_p3_q);
  assign mb = (PW+1)'(u2_p3_q) * (PW+1)'(t2_p3_q);
  assign mc = (PW+1)'(u3_p3_q) * (PW+1)'(t_p3_q);

  // stage 5: weight, truncate, clamp
  logic [SW-1:0] sa, sb, sc;
  logic [7:0]    pa_q, pb_q, pc_q;
  assign sa = SW'(pa_p4_q) * SW'(itrgb_pkg::ScaleA);
  assign sb = SW'(pb_p4_q) * SW'(itrgb_pkg::ScaleB);
  assign sc = SW'(pc_p4_q) * SW'(itrgb_pkg::ScaleC);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_p1_q  <= t_i;
      u_p1_q  <= One - {1'b0, t_i};

      t_p2_q  <= t_p1_q;
      u_p2_q  <= u_p1_q;
      t2_p2_q <= tt[PW-1:FRAC_BITS];
      u2_p2_q <= uu[PW:FRAC_BITS];

      t_p3_q  <= t_p2_q;
      u_p3_q  <= u_p2_q;
      t2_p3_q <= t2_p2_q;
      u2_p3_q <= u2_p2_q;
      t3_p3_q <= ttt[PW-1:FRAC_BITS];
      u3_p3_q <= uuu[PW:FRAC_BITS];

      pa_p4_q <= ma[PW:FRAC_BITS];
      pb_p4_q <= mb[PW:FRAC_BITS];
      pc_p4_q <= mc[PW:FRAC_BITS];

      pa_q <= clip8(sa[SW-1:FRAC_BITS]);
      pb_q <= clip8(sb[SW-1:FRAC_BITS]);
      pc_q <= clip8({1'b0, sc[SW-1:FRAC_BITS+1]});
    end
  end

  assign tag_o = tag_q[Stages-1];
  assign pa_o  = pa_q;
  assign pb_o  = pb_q;
  assign pc_o  = pc_q;

endmodule

`default_nettype wire

/* sv/itrgb_checker.sv */
// ----------------------------------------------------------------------------
// itrgb_checker
// port-level checks of the palette unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module itrgb_checker #(
  parameter int ITER_BITS = itrgb_pkg::IterBitsDefault
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic [ITER_BITS-1:0] iteration_count_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [7:0]           red_o,
  input wire logic [7:0]           green_o,
  input wire logic [7:0]           blue_o
);

  // highest value any of the three polynomials can reach
  localparam logic [7:0] PeakLevel = 8'd242;

  // a waiting pixel request keeps its count until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(iteration_count_i))
    else $error("pixel request changed while waiting");

  // a waiting colour holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_o)
      && $stable(green_o) && $stable(blue_o))
    else $error("result changed while stalled");

  // an empty output slot never blocks new pixels
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // a stalled output must hold back new pixels
  a_stall_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while output stalled");

  // no channel exceeds the palette peak
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> red_o <= PeakLevel && green_o <= PeakLevel
      && blue_o <= PeakLevel)
    else $error("colour above palette peak");

endmodule

bind iteration_to_rgb_palette_unit itrgb_checker #(
  .ITER_BITS(ITER_BITS)
) u_checker (.*);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the iteration count to rgb palette unit: pixel
// requests go in with random bursts and gaps, each colour coming out is held
// against a bit-exact fixed-point model of the three polynomials, over many
// limit and rotation settings, including a long output hold-off
// ----------------------------------------------------------------------------

module tb;

  localparam int IterBits   = itrgb_pkg::IterBitsDefault;
  localparam int FracBits   = itrgb_pkg::FracBitsDefault;
  localparam int IdxBits    = itrgb_pkg::CfgIdxBits;
  // entry stage, one divider stage per quotient bit, five multiplier stages,
  // output register
  localparam int Latency    = FracBits + 7;
  localparam int HoldCycles = 300;
  localparam int PhaseCount = 12;
  localparam int PhasePixels = 54;

  // register indexes beyond the two real registers, writes must be dropped
  localparam logic [IdxBits-1:0] RegSpareLo = 2'd2;
  localparam logic [IdxBits-1:0] RegSpareHi = 2'd3;
  // the unused rotation code
  localparam logic [1:0] RotSpare = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // pixel request side
  logic                 in_valid_i        = 1'b0;
  logic                 in_ready_o;
  logic [IterBits-1:0]  iteration_count_i = '0;

  // colour result side
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [7:0]           red_o;
  logic [7:0]           green_o;
  logic [7:0]           blue_o;

  // register write side
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [IdxBits-1:0]    cfg_index_i = '0;
  logic [IterBits-1:0]   cfg_data_i  = '0;

  // shadow copy of the two registers, updated when a write is accepted
  logic [IterBits-1:0] cur_max_iter = IterBits'(itrgb_pkg::MaxIterReset);
  logic [1:0]          cur_rotation = itrgb_pkg::RotNone;

  // colours still owed by the unit, oldest first
  colour_t pending_colours[$];

  int unsigned errors         = 0;
  int unsigned pixels_sent    = 0;
  int unsigned colours_seen   = 0;
  int unsigned settings_used  = 0;
  int unsigned input_stalls   = 0;
  int unsigned burst_left     = 0;
  bit          gaps_on        = 1'b1;
  // flipped to ask the receiver for one long hold-off
  bit          hold_toggle    = 1'b0;

  always #5 clk_i = ~clk_i;

  iteration_to_rgb_palette_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .iteration_count_i (iteration_count_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .red_o             (red_o),
    .green_o           (green_o),
    .blue_o            (blue_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // colour model
  // --------------------------------------------------------------------------

  // fixed-point product, truncated back to FracBits fraction bits
  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> FracBits;
  endfunction

  function automatic logic [7:0] clamp_colour(input logic [63:0] v);
    return (v > itrgb_pkg::ColourMax) ? 8'(itrgb_pkg::ColourMax) : v[7:0];
  endfunction

  function automatic colour_t predict_colour(input logic [IterBits-1:0] count);
    logic [63:0] t, u, t2, t3, u2, u3;
    logic [7:0]  pa, pb, pc;
    colour_t     c;
    c = '0;
    // zero count, count at or past the limit, and a zero limit are all black
    if (count == 0 || count >= cur_max_iter) return c;
    t  = (64'(count) << FracBits) / 64'(cur_max_iter);
    u  = (64'd1 << FracBits) - t;
    t2 = fx_mul(t, t);
    t3 = fx_mul(t2, t);
    u2 = fx_mul(u, u);
    u3 = fx_mul(u2, u);
    pa = clamp_colour((64'(itrgb_pkg::ScaleA) * fx_mul(u, t3)) >> FracBits);
    pb = clamp_colour((64'(itrgb_pkg::ScaleB) * fx_mul(u2, t2)) >> FracBits);
    // weight of the third polynomial is kept doubled, hence one more shift
    pc = clamp_colour((64'(itrgb_pkg::ScaleC) * fx_mul(u3, t)) >> (FracBits + 1));
    case (cur_rotation)
      itrgb_pkg::RotOne: begin
        c = '{red: pc, green: pa, blue: pb};
      end
      itrgb_pkg::RotTwo: begin
        c = '{red: pb, green: pc, blue: pa};
      end
      // no rotation, and the spare code behaves the same
      default: begin
        c = '{red: pa, green: pb, blue: pc};
      end
    endcase
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    errors++;
  endtask

  // outputs sampled at the edge, before anything driven at that edge lands
  always @(posedge clk_i) begin
    colour_t want;
    if (rst_ni && in_valid_i && !in_ready_o) input_stalls++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      colours_seen++;
      if (pending_colours.size() == 0) begin
        report_mismatch("colour with no request pending", 0,
                        32'({red_o, green_o, blue_o}));
      end else begin
        want = pending_colours.pop_front();
        if (red_o   !== want.red)
          report_mismatch("red",   32'(want.red),   32'(red_o));
        if (green_o !== want.green)
          report_mismatch("green", 32'(want.green), 32'(green_o));
        if (blue_o  !== want.blue)
          report_mismatch("blue",  32'(want.blue),  32'(blue_o));
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random ready and stall runs, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : colour_sink
    int unsigned run_left;
    int unsigned hold_left;
    bit          run_ready;
    bit          hold_seen;
    run_left  = 0;
    hold_left = 0;
    run_ready = 1'b0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          // ready runs are long and common, stall runs short
          run_ready = ($urandom_range(0, 2) != 0);
          run_left  = run_ready ? $urandom_range(1, 40) : $urandom_range(1, 8);
        end
        run_left--;
        out_ready_i <= run_ready;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender and register writes
  // --------------------------------------------------------------------------

  // one pixel request; valid stays high afterwards so bursts run back to back
  task automatic send_pixel(input logic [IterBits-1:0] count);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i        <= 1'b1;
    iteration_count_i <= count;
    do @(posedge clk_i); while (!in_ready_o);
    pending_colours.push_back(predict_colour(count));
    pixels_sent++;
  endtask

  // drop the request line and wait until every owed colour has come back
  task automatic drain_pixels();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_colours.size() != 0);
  endtask

  // one register write request, valid left high for a following write
  task automatic write_reg(input logic [IdxBits-1:0] idx,
                           input logic [IterBits-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      itrgb_pkg::RegMaxIter:  cur_max_iter = data;
      itrgb_pkg::RegRotation: cur_rotation = data[1:0];
      default: ; // spare indexes change nothing
    endcase
  endtask

  // only called with the unit idle
  task automatic set_palette(input logic [IterBits-1:0] max_iter,
                             input logic [IterBits-1:0] rot);
    write_reg(itrgb_pkg::RegMaxIter, max_iter);
    write_reg(itrgb_pkg::RegRotation, rot);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // counts spread over the interesting regions of the current limit
  function automatic logic [IterBits-1:0] pick_count();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return IterBits'($urandom_range(cur_max_iter, 16'hffff));
    if (pick == 2 || cur_max_iter < 2) return IterBits'($urandom());
    return IterBits'($urandom_range(1, cur_max_iter - 1));
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset limit of 256, no rotation: black ends and the curve in between
  task automatic test_reset_defaults();
    send_pixel(16'd0);
    send_pixel(16'd1);
    send_pixel(16'd64);
    send_pixel(16'd128);
    send_pixel(16'd192);
    send_pixel(16'd255);
    send_pixel(16'd256);
    send_pixel(16'd257);
    send_pixel(16'hffff);
    drain_pixels();
  endtask

  // widest limit, a limit of one, and a limit of zero (black, no division)
  task automatic test_limit_extremes();
    set_palette(16'hffff, IterBits'(itrgb_pkg::RotNone));
    send_pixel(16'd1);
    send_pixel(16'h8000);
    send_pixel(16'hfffe);
    send_pixel(16'hffff);
    drain_pixels();
    set_palette(16'd1, IterBits'(itrgb_pkg::RotNone));
    send_pixel(16'd0);
    send_pixel(16'd1);
    send_pixel(16'd2);
    drain_pixels();
    set_palette(16'd0, IterBits'(itrgb_pkg::RotOne));
    send_pixel(16'd0);
    send_pixel(16'd5);
    send_pixel(16'hffff);
    drain_pixels();
  endtask

  // each channel permutation, and the spare code acting as none
  task automatic test_rotations();
    set_palette(16'd100, IterBits'(itrgb_pkg::RotOne));
    send_pixel(16'd30);
    send_pixel(16'd70);
    drain_pixels();
    set_palette(16'd100, IterBits'(itrgb_pkg::RotTwo));
    send_pixel(16'd30);
    send_pixel(16'd70);
    drain_pixels();
    set_palette(16'd100, {14'h3fff, RotSpare});
    send_pixel(16'd30);
    send_pixel(16'd70);
    drain_pixels();
  endtask

  // writes to indexes past the register file must leave both registers alone
  task automatic test_spare_indexes();
    set_palette(16'd40, IterBits'(itrgb_pkg::RotTwo));
    @(posedge clk_i);
    write_reg(RegSpareLo, 16'h0003);
    write_reg(RegSpareHi, 16'hffff);
    cfg_valid_i <= 1'b0;
    send_pixel(16'd10);
    send_pixel(16'd25);
    drain_pixels();
  endtask

  // receiver holds off while pixels keep coming, the pipe fills and the
  // input has to stall, then everything drains in order
  task automatic test_backpressure();
    set_palette(16'd1000, IterBits'(itrgb_pkg::RotOne));
    gaps_on = 1'b0;
    hold_toggle <= ~hold_toggle;
    repeat (80) send_pixel(pick_count());
    drain_pixels();
    gaps_on = 1'b1;
  endtask

  // random limits and rotation words, full-width data so every bit moves
  task automatic test_random_phases();
    logic [IterBits-1:0] max_iter;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case ($urandom_range(0, 5))
        0:       max_iter = IterBits'($urandom_range(2, 24));
        1:       max_iter = 16'd1;
        2:       max_iter = 16'hffff;
        3:       max_iter = IterBits'($urandom());
        default: max_iter = IterBits'($urandom_range(100, 4000));
      endcase
      set_palette(max_iter, IterBits'($urandom()));
      if ($urandom_range(0, 3) == 0) begin
        @(posedge clk_i);
        write_reg($urandom_range(0, 1) ? RegSpareLo : RegSpareHi, IterBits'($urandom()));
        cfg_valid_i <= 1'b0;
      end
      // some phases run without sender gaps
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (PhasePixels) send_pixel(pick_count());
      drain_pixels();
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    settings_used = 1;

    test_reset_defaults();
    test_limit_extremes();
    test_rotations();
    test_spare_indexes();
    test_backpressure();
    test_random_phases();

    // let anything stray show up before the verdict
    repeat (4 * Latency) @(posedge clk_i);
    if (pending_colours.size() != 0)
      report_mismatch("colours never delivered", 0, pending_colours.size());

    $display("%0d pixels sent, %0d colours checked, %0d register settings",
             pixels_sent, colours_seen, settings_used);
    $display("%0d cycles with the pixel input held back by the unit", input_stalls);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout with %0d colours outstanding", pending_colours.size());
    $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
sv/itrgb_pkg.sv
sv/itrgb_divider.sv
sv/itrgb_poly.sv
sv/iteration_to_rgb_palette_unit.sv
sv/itrgb_checker.sv
tb/tb.sv
